/* design/led_pwm_fade_controller_core_assert.svh */
// -----------------------------------------------------------------------------
// LED PWM fade controller assertion macros
// Shared concurrent assertion forms used by the fade controller RTL.
// -----------------------------------------------------------------------------
`ifndef LED_PWM_FADE_CONTROLLER_CORE_ASSERT_SVH
`define LED_PWM_FADE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LPWMF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpwmf assertion failed");

// Next-cycle implication, checked outside reset.
`define LPWMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpwmf assertion failed");

`endif

/* design/lpwmf_pkg.sv */
// -----------------------------------------------------------------------------
// LED PWM fade controller package
// Payload types, request codes and fixed constants of the fade controller.
// -----------------------------------------------------------------------------
package lpwmf_pkg;

	// PWM resolution; the timer counts 0 .. DUTY_MAX and wraps.
	localparam int unsigned DUTY_BITS = 10;
	localparam int unsigned INT_BITS = 16;
	localparam int unsigned RATE_BITS = 16;
	localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};
	localparam logic [RATE_BITS-1:0] FADE_RATE_RST = RATE_BITS'(10);

	// Request codes; codes 5 to 7 are ignored.
	localparam logic [2:0] REQ_TICK = 3'd0;
	localparam logic [2:0] REQ_ON = 3'd1;
	localparam logic [2:0] REQ_OFF = 3'd2;
	localparam logic [2:0] REQ_TOGGLE = 3'd3;
	localparam logic [2:0] REQ_SET = 3'd4;

	typedef struct packed {
		logic [2:0] req_type;
		logic [INT_BITS-1:0] intensity_value;
	} lpwmf_req_t;

	typedef struct packed {
		logic led_lit;
		logic [DUTY_BITS-1:0] duty_level;
		logic fading;
	} lpwmf_rsp_t;

	// Input stage contents handed to the engine.
	typedef struct packed {
		logic valid;
		lpwmf_req_t req;
	} lpwmf_stage_t;

endpackage

/* design/lpwmf_in_stage.sv */
// -----------------------------------------------------------------------------
// LED PWM fade controller input stage
// Registers one request transaction and holds it until the engine takes it.
// -----------------------------------------------------------------------------
module lpwmf_in_stage
	import lpwmf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  lpwmf_req_t in_data,
	input  logic advance,
	output lpwmf_stage_t stage
);

	logic valid_s1;
	lpwmf_req_t req_s1;

	// The stage is free when empty or when its content moves on this cycle.
	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_data;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.req = req_s1;

endmodule

/* design/lpwmf_engine.sv */
// -----------------------------------------------------------------------------
// LED PWM fade controller engine
// Holds the PWM and fade state, applies one request per fire and forms the
// result from the updated state.
// -----------------------------------------------------------------------------
`include "led_pwm_fade_controller_core_assert.svh"

module lpwmf_engine
	import lpwmf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [RATE_BITS-1:0] cfg_wr_data,
	input  logic fire,
	input  lpwmf_req_t req,
	output lpwmf_rsp_t rsp
);

	logic [RATE_BITS-1:0] fade_rate_q;
	logic [DUTY_BITS-1:0] timer_q, timer_d;
	logic [DUTY_BITS-1:0] duty_q, duty_d;
	logic [DUTY_BITS-1:0] target_q, target_d;
	logic on_q, on_d;
	logic pwm_en_q, pwm_en_d;
	logic steady_q, steady_d;
	logic [RATE_BITS-1:0] div_q, div_d;

	logic do_on;
	logic do_off;
	logic [DUTY_BITS-1:0] set_level;

	assign do_on = ~on_q & ((req.req_type == REQ_ON) | (req.req_type == REQ_TOGGLE));
	assign do_off = on_q & ((req.req_type == REQ_OFF) | (req.req_type == REQ_TOGGLE));
	assign set_level = req.intensity_value[INT_BITS-1 -: DUTY_BITS];

	always_comb begin
		timer_d = timer_q;
		duty_d = duty_q;
		target_d = target_q;
		on_d = on_q;
		pwm_en_d = pwm_en_q;
		steady_d = steady_q;
		div_d = div_q;
		case (req.req_type)
			REQ_TICK: begin
				if (pwm_en_q) begin
					if (timer_q == DUTY_MAX) begin
						timer_d = '0;
						// One period has passed; advance the fade divider.
						if (div_q == fade_rate_q) begin
							div_d = '0;
							if (on_q) begin
								if (duty_q == target_q) begin
									steady_d = 1'b1;
									pwm_en_d = 1'b0;
								end else begin
									duty_d = duty_q + 1'b1;
								end
							end else begin
								if (duty_q == '0) begin
									steady_d = 1'b0;
									pwm_en_d = 1'b0;
								end else begin
									duty_d = duty_q - 1'b1;
								end
							end
						end else begin
							div_d = div_q + 1'b1;
						end
					end else begin
						timer_d = timer_q + 1'b1;
					end
				end
			end
			REQ_ON, REQ_OFF, REQ_TOGGLE: begin
				if (do_on || do_off) begin
					on_d = do_on;
					if (fade_rate_q == '0) begin
						steady_d = do_on;
						pwm_en_d = 1'b0;
					end else if (!pwm_en_q) begin
						div_d = '0;
						pwm_en_d = 1'b1;
					end
				end
			end
			REQ_SET: begin
				duty_d = set_level;
				target_d = set_level;
				if (timer_q > set_level) begin
					timer_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_rate_q <= FADE_RATE_RST;
		end else if (cfg_wr_en) begin
			fade_rate_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			duty_q <= DUTY_MAX;
			target_q <= DUTY_MAX;
			on_q <= 1'b0;
			pwm_en_q <= 1'b0;
			steady_q <= 1'b0;
			div_q <= '0;
		end else if (fire) begin
			timer_q <= timer_d;
			duty_q <= duty_d;
			target_q <= target_d;
			on_q <= on_d;
			pwm_en_q <= pwm_en_d;
			steady_q <= steady_d;
			div_q <= div_d;
		end
	end

	// The result reflects the state after this request.
	assign rsp.led_lit = pwm_en_d ? (timer_d < duty_d) : steady_d;
	assign rsp.duty_level = duty_d;
	assign rsp.fading = pwm_en_d;

	`LPWMF_ASSERT_NEXT(a_set_loads_target, clk, arst_n, fire && (req.req_type == REQ_SET), duty_q == target_q)
	`LPWMF_ASSERT_NEXT(a_timer_frozen_when_idle, clk, arst_n, !fire || !pwm_en_q, timer_q == $past(timer_q) || timer_q == '0)

endmodule

/* design/lpwmf_out_stage.sv */
// -----------------------------------------------------------------------------
// LED PWM fade controller output stage
// Result register that presents one result transaction until it is taken.
// -----------------------------------------------------------------------------
module lpwmf_out_stage
	import lpwmf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  lpwmf_rsp_t rsp,
	output logic advance,
	output logic out_valid,
	input  logic out_stall,
	output lpwmf_rsp_t out_data
);

	logic valid_s2;
	lpwmf_rsp_t rsp_s2;

	// A new result may enter when the register is empty or is drained now.
	assign advance = ~valid_s2 | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_s2 <= rsp;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = rsp_s2;

endmodule

/* design/led_pwm_fade_controller_core.sv */
// -----------------------------------------------------------------------------
// LED PWM fade controller core
// PWM timer with fade-in and fade-out toward a target intensity, driven by a
// stream of tick and command transactions.
// -----------------------------------------------------------------------------
//
//   Port group   Direction  Handshake              Carries
//   in_*         in         in_valid / in_stall    lpwmf_req_t request
//   out_*        out        out_valid / out_stall  lpwmf_rsp_t result
//   cfg_*        in         cfg_wr_en              fade_rate register
//
// Every request transaction yields exactly one result transaction; it is held
// in the input register and then in the result register. One transaction can
// be accepted in every cycle while the output is not stalled; the rate is set
// by the single engine update between the input register and the result
// register. A stall on the output backs up through the result register into
// the input register and then into in_stall. After reset the fade rate is 10,
// the LED is dark, PWM is off and the duty and target are at full scale.
// -----------------------------------------------------------------------------
`include "led_pwm_fade_controller_core_assert.svh"

module led_pwm_fade_controller_core
	import lpwmf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  lpwmf_req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output lpwmf_rsp_t out_data,
	input  logic cfg_wr_en,
	input  logic [RATE_BITS-1:0] cfg_wr_data
);

	lpwmf_stage_t stage;
	lpwmf_rsp_t rsp;
	logic advance;
	logic fire;

	// The input register holds a request until the result register can take
	// its result, so the engine state moves exactly once per request.
	lpwmf_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.advance  (advance),
		.stage    (stage)
	);

	// A request is applied to the engine in the cycle it moves on.
	assign fire = stage.valid & advance;

	lpwmf_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.req         (stage.req),
		.rsp         (rsp)
	);

	// The result register parts the engine from the consumer, so a new request
	// enters while a finished result still waits.
	lpwmf_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.rsp       (rsp),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`LPWMF_ASSERT_NOW(a_stall_needs_item, clk, arst_n, in_stall, stage.valid)
	`LPWMF_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire, out_valid)
	`LPWMF_ASSERT_NEXT(a_drain_empties, clk, arst_n, out_valid && !out_stall && !fire, !out_valid)

endmodule
